// ===== hdl/srfp_pkg.sv =====
// srfp_pkg: request, response and per-port record types for the stepper reply frame parser
// no dependencies; imported by stepper_reply_frame_parser and srfp_checker

package srfp_pkg;

  localparam logic [7:0] FN_POSITION = 8'h36;
  localparam logic [7:0] FN_STATUS   = 8'h3A;
  localparam logic [3:0] LEN_LONG    = 4'd8;
  localparam logic [3:0] LEN_SHORT   = 4'd4;
  localparam logic [7:0] CHECK_RESET = 8'd107;

  localparam logic [2:0] IDX_CODE    = 3'd1;
  localparam logic [2:0] IDX_ARG     = 3'd2;
  localparam logic [2:0] IDX_MAG_LO  = 3'd3;
  localparam logic [2:0] IDX_MAG_HI  = 3'd6;

  typedef struct packed {
    logic [1:0] port;
    logic [7:0] rx_byte;
  } rx_req_t;

  typedef struct packed {
    logic [1:0]         port_out;
    logic               frame_ok;
    logic signed [31:0] position;
    logic               pos_known;
    logic [7:0]         flag_byte;
    logic               flags_known;
    logic [7:0]         command_status;
    logic [31:0]        valid_frames;
    logic [31:0]        invalid_frames;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  cnt;
    logic        is_long;
    logic        is_status;
    logic [7:0]  arg;
    logic [31:0] mag;
  } ctx_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic               pos_seen;
    logic [7:0]         status;
    logic               status_seen;
    logic [7:0]         ack;
    logic [31:0]        good;
    logic [31:0]        bad;
  } stats_t;

endpackage

// ===== hdl/stepper_reply_frame_parser.sv =====
// stepper_reply_frame_parser: per-port reply frame assembly, check and decode
// depends on srfp_pkg; frame context and port statistics live in two PORTS-deep memories
// response path: a completing byte passes the s1 read register, then the output register
// throughput: one request per cycle, same port back to back, via a one-entry write forward;
// a held response stalls the input only while the byte being updated ends a frame
// reset: synchronous; clears per-entry valid bits, loads check_byte with 107, empties pipeline

module stepper_reply_frame_parser import srfp_pkg::*; #(
  parameter int PORTS = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    rx_valid,
  output logic    rx_ready,
  input  rx_req_t rx_data,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output rsp_t    rsp_data,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int AW = (PORTS > 1) ? $clog2(PORTS) : 1;

  logic [7:0] check_byte;

  ctx_t   ctx_mem   [PORTS];
  stats_t stats_mem [PORTS];
  logic [PORTS-1:0] ent_valid;

  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic [1:0]    s1_port;
  logic [7:0]    s1_byte;
  ctx_t          ctx_rd;
  stats_t        stats_rd;
  logic          rd_valid;

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  ctx_t          fwd_ctx;
  stats_t        fwd_stats;

  ctx_t          ctx_cur;
  ctx_t          ctx_new;
  stats_t        stats_cur;
  stats_t        stats_new;
  logic [3:0]    cnt_next;
  logic [3:0]    frame_len;
  logic          done;
  logic          ok;
  logic          s1_go;
  logic          rx_take;
  logic          rx_in_range;
  logic [AW-1:0] rx_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_byte <= CHECK_RESET;
    end else if (cfg_valid) begin
      check_byte <= cfg_data;
    end
  end

  assign rx_addr     = AW'(rx_data.port);
  assign rx_in_range = {30'd0, rx_data.port} < 32'(PORTS);
  assign rx_take     = rx_valid && rx_ready;
  assign s1_go       = s1_valid && (!done || !rsp_valid || rsp_ready);
  assign rx_ready    = !s1_valid || s1_go;

  // memory read port
  always_ff @(posedge clk) begin
    if (rx_take) begin
      ctx_rd   <= ctx_mem[rx_addr];
      stats_rd <= stats_mem[rx_addr];
      rd_valid <= ent_valid[rx_addr];
      s1_addr  <= rx_addr;
      s1_port  <= rx_data.port;
      s1_byte  <= rx_data.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_take) begin
      s1_valid <= rx_in_range;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // forward the write that landed in the same cycle as the read
  always_comb begin
    if (fwd_valid && fwd_addr == s1_addr) begin
      ctx_cur   = fwd_ctx;
      stats_cur = fwd_stats;
    end else if (rd_valid) begin
      ctx_cur   = ctx_rd;
      stats_cur = stats_rd;
    end else begin
      ctx_cur   = '0;
      stats_cur = '0;
    end
  end

  always_comb begin
    ctx_new     = ctx_cur;
    stats_new   = stats_cur;
    cnt_next    = {1'b0, ctx_cur.cnt} + 4'd1;
    ctx_new.cnt = cnt_next[2:0];
    if (ctx_cur.cnt == IDX_CODE) begin
      ctx_new.is_long   = (s1_byte == FN_POSITION);
      ctx_new.is_status = (s1_byte == FN_STATUS);
    end
    if (ctx_cur.cnt == IDX_ARG) begin
      ctx_new.arg = s1_byte;
    end
    if (ctx_cur.cnt >= IDX_MAG_LO && ctx_cur.cnt <= IDX_MAG_HI) begin
      ctx_new.mag = {ctx_cur.mag[23:0], s1_byte};
    end
    frame_len = ctx_new.is_long ? LEN_LONG : LEN_SHORT;
    done      = (cnt_next == frame_len);
    ok        = (s1_byte == check_byte);
    if (done) begin
      ctx_new.cnt     = '0;
      ctx_new.is_long = 1'b0;
      if (ok) begin
        if (ctx_cur.is_long) begin
          stats_new.position = (ctx_cur.arg != 8'd0) ? $signed(32'd0 - ctx_cur.mag)
                                                     : $signed(ctx_cur.mag);
          stats_new.pos_seen = 1'b1;
        end else if (ctx_cur.is_status) begin
          stats_new.status      = ctx_cur.arg;
          stats_new.status_seen = 1'b1;
        end else begin
          stats_new.ack = ctx_cur.arg;
        end
        stats_new.good = stats_cur.good + 32'd1;
      end else begin
        stats_new.bad = stats_cur.bad + 32'd1;
      end
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (s1_go) begin
      ctx_mem[s1_addr]   <= ctx_new;
      stats_mem[s1_addr] <= stats_new;
      fwd_addr           <= s1_addr;
      fwd_ctx            <= ctx_new;
      fwd_stats          <= stats_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (s1_go) begin
      ent_valid[s1_addr] <= 1'b1;
      fwd_valid          <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go && done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && done) begin
      rsp_data.port_out       <= s1_port;
      rsp_data.frame_ok       <= ok;
      rsp_data.position       <= stats_new.position;
      rsp_data.pos_known      <= stats_new.pos_seen;
      rsp_data.flag_byte      <= stats_new.status;
      rsp_data.flags_known    <= stats_new.status_seen;
      rsp_data.command_status <= stats_new.ack;
      rsp_data.valid_frames   <= stats_new.good;
      rsp_data.invalid_frames <= stats_new.bad;
    end
  end

endmodule

// ===== hdl/srfp_checker.sv =====
// srfp_checker: port-level assertions for stepper_reply_frame_parser
// depends on srfp_pkg; attached to the top level by the bind at the end of this file

module srfp_checker import srfp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    rx_valid,
  input logic    rx_ready,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input rsp_t    rsp_data
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a fresh response must be preceded by a taken request
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(rx_valid && rx_ready, 2))
    else $error("response without a matching request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_data))
    else $error("response payload changed while stalled");

endmodule

bind stepper_reply_frame_parser srfp_checker u_srfp_checker (.*);
